FILE: sv/tgpm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package tgpm_pkg;

	// Geometry
	localparam int FRAME_WIDTH  = 132;
	localparam int PAGE_COUNT   = 8;
	localparam int GLYPH_WIDTH  = 9;
	localparam int TEXT_ROWS    = 6;
	localparam int TEXT_COLS    = 14;
	localparam int GLYPH_COUNT  = 128;
	localparam int DEAD_LEFT    = 2;
	localparam int PAGE_HEIGHT  = 8;
	localparam int GLYPH_HEIGHT = 10;

	localparam int FRAME_DEPTH = PAGE_COUNT * FRAME_WIDTH;
	localparam int FONT_DEPTH  = GLYPH_COUNT * GLYPH_WIDTH;
	localparam int FADDR_W     = $clog2(FRAME_DEPTH);
	localparam int FIDX_W      = $clog2(FONT_DEPTH);
	localparam int FCOL_W      = $clog2(TEXT_COLS * GLYPH_WIDTH + DEAD_LEFT + FRAME_WIDTH);
	localparam int PAGE_W      = 4;
	localparam int QUEUE_DEPTH = 2;

	localparam logic [15:0] GLYPH_BITS    = 16'h03FF;
	localparam logic [15:0] UNDERLINE_BIT = 16'h0200;
	localparam logic [15:0] ALL_ONES      = 16'hFFFF;
	localparam logic [7:0]  GLYPH_MASK    = 8'h7F;

	typedef enum logic [1:0] {
		CMD_FONT  = 2'd0,
		CMD_CHAR  = 2'd1,
		CMD_CLEAR = 2'd2,
		CMD_READ  = 2'd3
	} cmd_t;

	// Classified request handed from front to back
	typedef struct packed {
		cmd_t              cmd;
		logic              bad;
		logic [PAGE_W-1:0] page;
		logic [2:0]        shift;
		logic [15:0]       keep;
		logic [15:0]       tog;
		logic [FCOL_W-1:0] fcol_base;
		logic [FIDX_W:0]   fbase;
		logic [10:0]       font_index;
		logic [9:0]        font_word;
		logic [10:0]       frame_address;
	} item_t;

endpackage
`default_nettype wire

FILE: sv/tgpm_front.sv
`timescale 1ns / 1ps
`default_nettype none
module tgpm_front (
	input  wire logic [1:0]     command,
	input  wire logic [2:0]     text_row,
	input  wire logic [3:0]     text_col,
	input  wire logic [7:0]     char_code,
	input  wire logic           underline,
	input  wire logic [10:0]    font_index,
	input  wire logic [9:0]     font_word,
	input  wire logic [10:0]    frame_address,
	output tgpm_pkg::item_t     item
);

	logic [6:0]  row_x10;
	logic [15:0] tog_raw;
	logic        row_bad;
	logic        col_bad;

	// Row geometry and range checks
	always_comb begin
		row_x10 = 7'(text_row) * 7'(tgpm_pkg::GLYPH_HEIGHT);
		row_bad = 32'(text_row) >= tgpm_pkg::TEXT_ROWS;
		col_bad = 32'(text_col) >= tgpm_pkg::TEXT_COLS;
		tog_raw = underline ? tgpm_pkg::UNDERLINE_BIT : 16'h0000;
		if (char_code[7]) begin
			tog_raw = tog_raw ^ tgpm_pkg::GLYPH_BITS;
		end
	end

	// Classification
	always_comb begin
		item.cmd = tgpm_pkg::cmd_t'(command);
		case (item.cmd)
			tgpm_pkg::CMD_FONT:  item.bad = 32'(font_index) >= tgpm_pkg::FONT_DEPTH;
			tgpm_pkg::CMD_CHAR:  item.bad = row_bad | col_bad;
			tgpm_pkg::CMD_CLEAR: item.bad = row_bad;
			tgpm_pkg::CMD_READ:  item.bad = 32'(frame_address) >= tgpm_pkg::FRAME_DEPTH;
			default:             item.bad = 1'b1;
		endcase
		item.page      = tgpm_pkg::PAGE_W'(row_x10 / tgpm_pkg::PAGE_HEIGHT);
		item.shift     = 3'({text_row, 1'b0});
		item.keep      = (tgpm_pkg::GLYPH_BITS << item.shift) ^ tgpm_pkg::ALL_ONES;
		item.tog       = tog_raw << item.shift;
		// row clear sweeps the whole page from column zero
		if (item.cmd == tgpm_pkg::CMD_CLEAR) begin
			item.fcol_base = '0;
		end else begin
			item.fcol_base = tgpm_pkg::FCOL_W'(text_col)
				* tgpm_pkg::FCOL_W'(tgpm_pkg::GLYPH_WIDTH)
				+ tgpm_pkg::FCOL_W'(tgpm_pkg::DEAD_LEFT);
		end
		item.fbase     = (tgpm_pkg::FIDX_W + 1)'(char_code & tgpm_pkg::GLYPH_MASK)
			* (tgpm_pkg::FIDX_W + 1)'(tgpm_pkg::GLYPH_WIDTH);
		item.font_index    = font_index;
		item.font_word     = font_word;
		item.frame_address = frame_address;
	end

endmodule
`default_nettype wire

FILE: sv/tgpm_queue.sv
`timescale 1ns / 1ps
`default_nettype none
module tgpm_queue (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            wr_en,
	input  tgpm_pkg::item_t      wr_item,
	input  wire logic            rd_en,
	output tgpm_pkg::item_t      rd_item,
	output logic                 q_full,
	output logic                 q_empty
);

	localparam int PTR_W = $clog2(tgpm_pkg::QUEUE_DEPTH);

	tgpm_pkg::item_t    mem_q [tgpm_pkg::QUEUE_DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [PTR_W:0]     count_q;

	assign q_full  = count_q == (PTR_W + 1)'(tgpm_pkg::QUEUE_DEPTH);
	assign q_empty = count_q == '0;
	assign rd_item = mem_q[rd_ptr_q];

	// Storage
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_item;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (wr_en && !rd_en) begin
				count_q <= count_q + 1'b1;
			end else if (rd_en && !wr_en) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) q_full |-> !wr_en)
		else $error("queue write while full");
	assert property (@(posedge clk) disable iff (!arst_n) q_empty |-> !rd_en)
		else $error("queue read while empty");
	assert property (@(posedge clk) disable iff (!arst_n)
		wr_en && !rd_en |=> !q_empty)
		else $error("queue lost a request");

endmodule
`default_nettype wire

FILE: sv/tgpm_back.sv
`timescale 1ns / 1ps
`default_nettype none
module tgpm_back (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           q_empty,
	input  tgpm_pkg::item_t     q_item,
	output logic                q_pop,
	output logic                clearing,
	input  wire logic           pop,
	output logic                empty,
	output logic [7:0]          frame_byte,
	output logic [0:0]          status
);

	localparam int AW = tgpm_pkg::FADDR_W + 2;

	typedef enum logic [3:0] {
		S_CLEAR, S_IDLE, S_FONT, S_FRD0, S_FRD1,
		S_RLO, S_RHI, S_WLO, S_WHI, S_DONE
	} state_t;

	state_t                       state_q;
	tgpm_pkg::item_t              cur_q;
	logic [tgpm_pkg::FCOL_W-1:0]  cnt_q;
	logic [tgpm_pkg::FADDR_W-1:0] clr_q;
	logic [7:0]                   lo_q;
	logic [9:0]                   w_q;
	logic [7:0]                   res_hi_q;
	logic [7:0]                   byte_q;
	logic                         stat_q;
	logic                         out_valid_q;
	logic [7:0]                   frame_byte_q;
	logic                         status_q;

	logic [7:0] frame_mem [tgpm_pkg::FRAME_DEPTH];
	logic [9:0] font_mem  [tgpm_pkg::FONT_DEPTH];
	logic [7:0] frame_rd_q;
	logic [9:0] font_rd_q;

	logic [tgpm_pkg::FCOL_W-1:0]  fcol;
	logic [tgpm_pkg::FCOL_W-1:0]  cnt_last;
	logic [tgpm_pkg::FIDX_W:0]    fi;
	logic                         fi_ok;
	logic                         col_ok;
	logic                         hi_ok;
	logic [AW-1:0]                ilo;
	logic [AW-1:0]                ihi;
	logic [15:0]                  put;
	logic [15:0]                  res;
	logic                         frame_we;
	logic [tgpm_pkg::FADDR_W-1:0] frame_wa;
	logic [7:0]                   frame_wd;
	logic [tgpm_pkg::FADDR_W-1:0] frame_ra;
	logic                         font_we;
	logic                         post;

	// Column addressing for the current request
	always_comb begin
		fcol     = cur_q.fcol_base + cnt_q;
		cnt_last = (cur_q.cmd == tgpm_pkg::CMD_CHAR)
			? tgpm_pkg::FCOL_W'(tgpm_pkg::GLYPH_WIDTH - 1)
			: tgpm_pkg::FCOL_W'(tgpm_pkg::FRAME_WIDTH - 1);
		fi       = cur_q.fbase + (tgpm_pkg::FIDX_W + 1)'(cnt_q);
		fi_ok    = 32'(fi) < tgpm_pkg::FONT_DEPTH;
		col_ok   = 32'(fcol) < tgpm_pkg::FRAME_WIDTH && 32'(cur_q.page) < tgpm_pkg::PAGE_COUNT;
		hi_ok    = 32'(cur_q.page) + 1 < tgpm_pkg::PAGE_COUNT;
		ilo      = AW'(cur_q.page) * AW'(tgpm_pkg::FRAME_WIDTH) + AW'(fcol);
		ihi      = ilo + AW'(tgpm_pkg::FRAME_WIDTH);
		put      = (cur_q.cmd == tgpm_pkg::CMD_CHAR)
			? ((16'(w_q) << cur_q.shift) ^ cur_q.tog) : 16'h0000;
		res      = ({hi_ok ? frame_rd_q : 8'h00, lo_q} & cur_q.keep) | put;
	end

	// Memory port control
	always_comb begin
		frame_we = 1'b0;
		frame_wa = ilo[tgpm_pkg::FADDR_W-1:0];
		frame_wd = res[7:0];
		frame_ra = ilo[tgpm_pkg::FADDR_W-1:0];
		case (state_q)
			S_CLEAR: begin
				frame_we = 1'b1;
				frame_wa = clr_q;
				frame_wd = 8'h00;
			end
			S_FRD0: frame_ra = cur_q.frame_address[tgpm_pkg::FADDR_W-1:0];
			S_RHI:  frame_ra = ihi[tgpm_pkg::FADDR_W-1:0];
			S_WLO:  frame_we = col_ok;
			S_WHI: begin
				frame_we = col_ok && hi_ok;
				frame_wa = ihi[tgpm_pkg::FADDR_W-1:0];
				frame_wd = res_hi_q;
			end
			default: frame_we = 1'b0;
		endcase
		font_we = state_q == S_FONT;
	end

	// Frame store
	always_ff @(posedge clk) begin
		if (frame_we) begin
			frame_mem[frame_wa] <= frame_wd;
		end
		frame_rd_q <= frame_mem[frame_ra];
	end

	// Font store
	always_ff @(posedge clk) begin
		if (font_we) begin
			font_mem[cur_q.font_index[tgpm_pkg::FIDX_W-1:0]] <= cur_q.font_word;
		end
		font_rd_q <= font_mem[fi[tgpm_pkg::FIDX_W-1:0]];
	end

	assign q_pop      = state_q == S_IDLE && !q_empty;
	assign clearing   = state_q == S_CLEAR;
	assign post       = state_q == S_DONE && (!out_valid_q || pop);
	assign empty      = !out_valid_q;
	assign frame_byte = frame_byte_q;
	assign status     = status_q;

	// Sequencer and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (post) begin
				out_valid_q  <= 1'b1;
				frame_byte_q <= byte_q;
				status_q     <= stat_q;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == tgpm_pkg::FADDR_W'(tgpm_pkg::FRAME_DEPTH - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (!q_empty) begin
						cur_q  <= q_item;
						cnt_q  <= '0;
						byte_q <= 8'h00;
						stat_q <= q_item.bad;
						if (q_item.bad) begin
							state_q <= S_DONE;
						end else begin
							case (q_item.cmd)
								tgpm_pkg::CMD_FONT: state_q <= S_FONT;
								tgpm_pkg::CMD_READ: state_q <= S_FRD0;
								default:            state_q <= S_RLO;
							endcase
						end
					end
				end
				S_FONT: state_q <= S_DONE;
				S_FRD0: state_q <= S_FRD1;
				S_FRD1: begin
					byte_q  <= frame_rd_q;
					state_q <= S_DONE;
				end
				S_RLO: state_q <= S_RHI;
				S_RHI: begin
					lo_q    <= frame_rd_q;
					w_q     <= fi_ok ? font_rd_q : 10'h000;
					state_q <= S_WLO;
				end
				S_WLO: begin
					res_hi_q <= res[15:8];
					state_q  <= S_WHI;
				end
				S_WHI: begin
					if (cnt_q == cnt_last) begin
						state_q <= S_DONE;
					end else begin
						cnt_q   <= cnt_q + 1'b1;
						state_q <= S_RLO;
					end
				end
				S_DONE: begin
					if (post) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_IDLE |-> !frame_we)
		else $error("frame write outside a request");
	assert property (@(posedge clk) disable iff (!arst_n)
		post |=> out_valid_q)
		else $error("result not posted");
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_WHI |-> cnt_q <= cnt_last)
		else $error("column counter overrun");
	assert property (@(posedge clk) disable iff (!arst_n)
		clearing |-> !q_pop)
		else $error("request taken during clearing pass");

endmodule
`default_nettype wire

FILE: sv/text_glyph_page_merge_top.sv
`timescale 1ns / 1ps
`default_nettype none
// Request handling: a font load writes one font word, a frame read fetches one byte,
// write-char sweeps 9 columns and row clear all 132 columns (one frame store port
// pair; each column reads and rewrites two bytes in states RLO, RHI, WLO, WHI).
// Throughput: one request at a time in the back end; a two-entry queue takes requests meanwhile.
// Reset: arst_n clears control; then a pass zeroes all 1056 frame store bytes, full held high.
module text_glyph_page_merge_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	output logic             full,
	input  wire logic [1:0]  command,
	input  wire logic [2:0]  text_row,
	input  wire logic [3:0]  text_col,
	input  wire logic [7:0]  char_code,
	input  wire logic        underline,
	input  wire logic [10:0] font_index,
	input  wire logic [9:0]  font_word,
	input  wire logic [10:0] frame_address,
	output logic             empty,
	input  wire logic        pop,
	output logic [7:0]       frame_byte,
	output logic [0:0]       status
);

	tgpm_pkg::item_t in_item;
	tgpm_pkg::item_t head_item;
	logic            q_full;
	logic            q_empty;
	logic            q_pop;
	logic            clearing;
	logic            accept;

	assign full   = q_full | clearing;
	assign accept = push && !full;

	tgpm_front u_front (
		.command       (command),
		.text_row      (text_row),
		.text_col      (text_col),
		.char_code     (char_code),
		.underline     (underline),
		.font_index    (font_index),
		.font_word     (font_word),
		.frame_address (frame_address),
		.item          (in_item)
	);

	tgpm_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (accept),
		.wr_item (in_item),
		.rd_en   (q_pop),
		.rd_item (head_item),
		.q_full  (q_full),
		.q_empty (q_empty)
	);

	tgpm_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_empty    (q_empty),
		.q_item     (head_item),
		.q_pop      (q_pop),
		.clearing   (clearing),
		.pop        (pop),
		.empty      (empty),
		.frame_byte (frame_byte),
		.status     (status)
	);

endmodule
`default_nettype wire
